[rtl/core/ybkf_pkg.sv]
// Package for the yaw / gyro-bias Kalman filter: sequencer codes,
// fixed-point constants and saturation helpers. No dependencies.
package ybkf_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_WRAP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } st_t;

  // multiply passes, in issue order
  typedef enum logic [3:0] {
    OP_YAW_PRED,
    OP_COV_BB_DT,
    OP_COV_BY_DT,
    OP_COV_A01_DT,
    OP_YAW_UPD,
    OP_BIAS_UPD,
    OP_P00_UPD,
    OP_P01_UPD,
    OP_P10_UPD,
    OP_P11_UPD
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_NOISE_YAW  = 3'd0,
    REG_NOISE_BIAS = 3'd1,
    REG_MEAS_NOISE = 3'd2,
    REG_INIT_YAW   = 3'd3,
    REG_INIT_BIAS  = 3'd4
  } cfg_reg_t;

  localparam logic signed [34:0] PI_Q24      = 35'sd52707179;
  localparam logic signed [34:0] NEG_PI_Q24  = -35'sd52707179;
  localparam logic signed [34:0] TWO_PI_Q24  = 35'sd105414357;
  localparam logic signed [47:0] COV_YY_INIT = 48'sd703687441777;
  localparam logic signed [47:0] COV_BB_INIT = 48'sd70368744178;
  localparam logic signed [50:0] ONE_Q46     = 51'sd70368744177664;
  localparam logic [62:0]        MAG_CAP     = 63'h4000_0000_0000_0000;

  localparam logic [46:0] NOISE_YAW_RST  = 47'd703687442;
  localparam logic [46:0] NOISE_BIAS_RST = 47'd70368744;
  localparam logic [46:0] MEAS_NOISE_RST = 47'd70368744178;

  // clamp a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if ((&v[65:31]) || !(|v[65:31])) return v[31:0];
    else if (v[65]) return 32'sh8000_0000;
    else return 32'sh7FFF_FFFF;
  endfunction

  // clamp a wide signed sum to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if ((&v[65:47]) || !(|v[65:47])) return v[47:0];
    else if (v[65]) return 48'sh8000_0000_0000;
    else return 48'sh7FFF_FFFF_FFFF;
  endfunction

endpackage

[rtl/core/ybkf_if.sv]
// Channel interfaces of the yaw / gyro-bias Kalman filter: input words,
// result words and configuration writes. No dependencies.
interface ybkf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] gyro_rate;
  logic signed [31:0] measured_yaw;
  logic [23:0]        time_step;
  modport source(output valid, action, gyro_rate, measured_yaw, time_step, input ready);
  modport sink(input valid, action, gyro_rate, measured_yaw, time_step, output ready);
endinterface

interface ybkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] yaw_out;
  logic signed [31:0] bias_out;
  modport source(output valid, yaw_out, bias_out, input ready);
  modport sink(input valid, yaw_out, bias_out, output ready);
endinterface

interface ybkf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/yaw_bias_kalman_filter.sv]
// Yaw / gyro-bias Kalman filter, fixed point.
// Channels: in_ch takes one word per sample: action 0 runs a filter step on
// gyro_rate, measured_yaw and time_step; action 1 reloads yaw and bias from
// the initial_yaw / initial_bias registers and the covariance from its
// starting values. Each accepted word yields one out_ch word with the yaw
// and bias estimate after it. cfg_ch writes the noise and initial-value
// registers by index; it is always ready and should be written while idle.
// Sequence: a filter step runs ten passes of the shared multiplier and, when
// the innovation variance is positive, two serial gain divisions, one
// quotient bit per cycle. A reinitialize word goes from accept straight to
// the done state and then the output register. in_ch is ready only while
// the sequencer idles, one word in flight at a time.
// The result sits in an output register; a stalled receiver holds the
// finished result there, and a following word may be accepted and worked on
// meanwhile, waiting at its end until the register frees.
// Reset (synchronous, rst_n low) loads the register defaults, zero yaw and
// bias and the starting covariance; no clearing pass is needed.
// Depends on ybkf_pkg, ybkf_if, ybkf_mul and ybkf_div.
module yaw_bias_kalman_filter (
  input  logic      clk,
  input  logic      rst_n,
  ybkf_in_if.sink   in_ch,
  ybkf_out_if.source out_ch,
  ybkf_cfg_if.sink  cfg_ch
);
  import ybkf_pkg::*;

  st_t state_r, state_nxt;
  op_t op_r;
  logic div_sel_r;

  // configuration
  logic [46:0] qy_r, qb_r, rm_r;
  logic signed [31:0] iyaw_r, ibias_r;

  // filter state
  logic signed [31:0] yaw_r, bias_r;
  logic signed [47:0] p00_r, p01_r, p10_r, p11_r;

  // working registers
  logic signed [31:0] rate_r, meas_r, yawp_r;
  logic [23:0]        tq_r;
  logic signed [50:0] a00w_r, a01w_r;
  logic signed [47:0] a00_r, a01_r, a10_r, a11_r, g0_r, g1_r;
  logic signed [34:0] innov_r;
  logic [47:0]        sden_r;

  // output word
  logic               out_valid_r;
  logic signed [31:0] out_yaw_r, out_bias_r;

  // shared unit hookup
  logic               mul_start, mul_frac46, mul_done;
  logic signed [50:0] mul_a, mul_b, omg, tq_ext;
  logic signed [63:0] mul_res;
  logic               div_start, div_done;
  logic signed [47:0] div_num, div_q;

  logic               in_acc, out_load;
  logic signed [34:0] innov0, innov1, innov2;
  logic signed [48:0] sden;
  logic               sden_pos;

  ybkf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .frac46(mul_frac46), .done(mul_done), .result(mul_res)
  );

  ybkf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(sden_r),
    .done(div_done), .quot(div_q)
  );

  // innovation wrap and innovation variance
  always_comb begin
    innov0 = 35'(meas_r) - 35'(yawp_r);
    innov1 = (innov0 > PI_Q24) ? innov0 - TWO_PI_Q24 : innov0;
    innov2 = (innov1 < NEG_PI_Q24) ? innov1 + TWO_PI_Q24 : innov1;
    sden     = 49'(a00_r) + $signed({2'b00, rm_r});
    sden_pos = !sden[48] && (|sden[47:0]);
  end

  // multiplier operand select
  assign omg    = ONE_Q46 - 51'(g0_r);
  assign tq_ext = $signed({27'd0, tq_r});
  assign div_num = div_sel_r ? a10_r : a00_r;

  always_comb begin
    mul_frac46 = 1'b1;
    unique case (op_r)
      OP_YAW_PRED: begin
        mul_a = 51'(rate_r) - 51'(bias_r); mul_b = tq_ext; mul_frac46 = 1'b0;
      end
      OP_COV_BB_DT:  begin mul_a = 51'(p11_r); mul_b = tq_ext; mul_frac46 = 1'b0; end
      OP_COV_BY_DT:  begin mul_a = 51'(p10_r); mul_b = tq_ext; mul_frac46 = 1'b0; end
      OP_COV_A01_DT: begin mul_a = a01w_r;     mul_b = tq_ext; mul_frac46 = 1'b0; end
      OP_YAW_UPD:    begin mul_a = 51'(g0_r);  mul_b = 51'(innov_r); end
      OP_BIAS_UPD:   begin mul_a = 51'(g1_r);  mul_b = 51'(innov_r); end
      OP_P00_UPD:    begin mul_a = omg;        mul_b = 51'(a00_r); end
      OP_P01_UPD:    begin mul_a = omg;        mul_b = 51'(a01_r); end
      OP_P10_UPD:    begin mul_a = 51'(g1_r);  mul_b = 51'(a00_r); end
      OP_P11_UPD:    begin mul_a = 51'(g1_r);  mul_b = 51'(a01_r); end
      default:       begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = in_ch.action ? ST_DONE : ST_MUL_GO;
      ST_MUL_GO:   state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (op_r == OP_COV_A01_DT)    state_nxt = ST_WRAP;
          else if (op_r == OP_P11_UPD)  state_nxt = ST_DONE;
          else                          state_nxt = ST_MUL_GO;
        end
      end
      ST_WRAP:     state_nxt = sden_pos ? ST_DIV_GO : ST_MUL_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = div_sel_r ? ST_MUL_GO : ST_DIV_GO;
      ST_DONE:     if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    mul_start   = (state_r == ST_MUL_GO);
    div_start   = (state_r == ST_DIV_GO);
    out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
    in_acc      = in_ch.valid && (state_r == ST_IDLE);
  end

  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.yaw_out  = out_yaw_r;
  assign out_ch.bias_out = out_bias_r;

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_YAW_PRED;
      div_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      qy_r        <= NOISE_YAW_RST;
      qb_r        <= NOISE_BIAS_RST;
      rm_r        <= MEAS_NOISE_RST;
      iyaw_r      <= '0;
      ibias_r     <= '0;
      yaw_r       <= '0;
      bias_r      <= '0;
      p00_r       <= COV_YY_INIT;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= COV_BB_INIT;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_NOISE_YAW:  qy_r    <= cfg_ch.data[46:0];
          REG_NOISE_BIAS: qb_r    <= cfg_ch.data[46:0];
          REG_MEAS_NOISE: rm_r    <= cfg_ch.data[46:0];
          REG_INIT_YAW:   iyaw_r  <= cfg_ch.data[31:0];
          REG_INIT_BIAS:  ibias_r <= cfg_ch.data[31:0];
          default: ;
        endcase
      end

      // accept: reinitialize or start the step
      if (in_acc) begin
        op_r <= OP_YAW_PRED;
        if (in_ch.action) begin
          yaw_r  <= iyaw_r;
          bias_r <= ibias_r;
          p00_r  <= COV_YY_INIT;
          p01_r  <= '0;
          p10_r  <= '0;
          p11_r  <= COV_BB_INIT;
        end
      end

      // state writeback of the update passes
      if (state_r == ST_MUL_WAIT && mul_done) begin
        unique case (op_r)
          OP_YAW_UPD:  yaw_r  <= sat32(66'(yawp_r) + 66'(mul_res));
          OP_BIAS_UPD: bias_r <= sat32(66'(bias_r) + 66'(mul_res));
          OP_P00_UPD:  p00_r  <= sat48(66'(mul_res));
          OP_P01_UPD:  p01_r  <= sat48(66'(mul_res));
          OP_P10_UPD:  p10_r  <= sat48(66'(a10_r) - 66'(mul_res));
          OP_P11_UPD:  p11_r  <= sat48(66'(a11_r) - 66'(mul_res));
          default: ;
        endcase
        if (op_r != OP_COV_A01_DT && op_r != OP_P11_UPD) op_r <= op_t'(op_r + 4'd1);
      end

      if (state_r == ST_WRAP) begin
        op_r      <= OP_YAW_UPD;
        div_sel_r <= 1'b0;
      end
      if (state_r == ST_DIV_WAIT && div_done) div_sel_r <= 1'b1;

      // output word register
      if (out_load)           out_valid_r <= 1'b1;
      else if (out_ch.ready)  out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r <= in_ch.gyro_rate;
      meas_r <= in_ch.measured_yaw;
      tq_r   <= in_ch.time_step;
    end
    if (state_r == ST_MUL_WAIT && mul_done) begin
      unique case (op_r)
        OP_YAW_PRED:  yawp_r <= sat32(66'(yaw_r) + 66'(mul_res));
        OP_COV_BB_DT: begin
          a01w_r <= 51'(66'(p01_r) - 66'(mul_res));
          a10_r  <= sat48(66'(p10_r) - 66'(mul_res));
        end
        OP_COV_BY_DT: a00w_r <= 51'(66'(p00_r) - 66'(mul_res));
        OP_COV_A01_DT: begin
          a00_r <= sat48(66'(a00w_r) - 66'(mul_res) + $signed({19'd0, qy_r}));
          a11_r <= sat48(66'(p11_r) + $signed({19'd0, qb_r}));
          a01_r <= sat48(66'(a01w_r));
        end
        default: ;
      endcase
    end
    if (state_r == ST_WRAP) begin
      innov_r <= innov2;
      sden_r  <= sden[47:0];
      if (!sden_pos) begin
        g0_r <= '0;
        g1_r <= '0;
      end
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      if (div_sel_r) g1_r <= div_q;
      else           g0_r <= div_q;
    end
    if (out_load) begin
      out_yaw_r  <= yaw_r;
      out_bias_r <= bias_r;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted word takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still ready after accept");

  // shared units only report while the sequencer waits on them
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL_WAIT)
    else $error("multiplier done outside its wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider done outside its wait state");

  // divider only runs on a positive innovation variance
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_GO |-> sden_r != '0)
    else $error("division started with zero denominator");

  // a finished word waits while the output register is full and stalled
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && !out_ch.ready |=> state_r == ST_DONE)
    else $error("result overwrote a stalled output word");
`endif

endmodule

[rtl/core/ybkf_mul.sv]
// Shared rounding multiplier: 50x50-bit magnitude product from four
// 25x25 partial products, round to nearest and shift by 24 or 46, cap at 2^62.
// Depends on ybkf_pkg.
module ybkf_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [50:0] op_a,
  input  logic signed [50:0] op_b,
  input  logic               frac46,
  output logic               done,
  output logic signed [63:0] result
);
  import ybkf_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd5;
  localparam logic [2:0] PP_STEPS  = 3'd4;

  logic        busy_r, done_r, pp_v_r, neg_r, sel_r;
  logic [2:0]  step_r;
  logic [49:0] ma_r, mb_r, pp_r;
  logic [1:0]  ppsh_r;
  logic [99:0] acc_r;
  logic signed [63:0] res_r;

  logic [49:0] mag_a, mag_b, pp_w;
  logic [24:0] a_chunk, b_chunk;
  logic [99:0] pp_sh, shv;
  logic [62:0] capped;

  // operand magnitudes
  always_comb begin
    mag_a = op_a[50] ? 50'(-op_a) : 50'(op_a);
    mag_b = op_b[50] ? 50'(-op_b) : 50'(op_b);
  end

  // partial product select and weight
  assign a_chunk = step_r[1] ? ma_r[49:25] : ma_r[24:0];
  assign b_chunk = step_r[0] ? mb_r[49:25] : mb_r[24:0];
  assign pp_w    = a_chunk * b_chunk;

  always_comb begin
    unique case (ppsh_r)
      2'd0:    pp_sh = 100'(pp_r);
      2'd1:    pp_sh = 100'(pp_r) << 25;
      2'd2:    pp_sh = 100'(pp_r) << 50;
      default: pp_sh = '0;
    endcase
  end

  // final shift and cap
  always_comb begin
    shv    = sel_r ? (acc_r >> 46) : (acc_r >> 24);
    capped = (shv > 100'(MAG_CAP)) ? MAG_CAP : shv[62:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pp_v_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        pp_v_r <= 1'b0;
      end else if (busy_r) begin
        pp_v_r <= (step_r < PP_STEPS);
        step_r <= step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= mag_a;
      mb_r  <= mag_b;
      neg_r <= op_a[50] ^ op_b[50];
      sel_r <= frac46;
      acc_r <= frac46 ? (100'd1 << 45) : (100'd1 << 23);
    end else if (busy_r) begin
      if (step_r < PP_STEPS) begin
        pp_r   <= pp_w;
        ppsh_r <= {1'b0, step_r[1]} + {1'b0, step_r[0]};
      end
      if (pp_v_r) acc_r <= acc_r + pp_sh;
      if (step_r == LAST_STEP)
        res_r <= neg_r ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

[rtl/core/ybkf_div.sv]
// Serial gain divider: num / den in Q2.46, one quotient bit a cycle,
// truncated toward zero, saturated at 2^47-1. Depends on ybkf_pkg.
module ybkf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] num,
  input  logic [47:0]        den,
  output logic               done,
  output logic signed [47:0] quot
);
  import ybkf_pkg::*;

  localparam logic [5:0] FRAC_BITS = 6'd46;

  logic        busy_r, init_r, done_r, neg_r;
  logic [5:0]  cnt_r;
  logic [47:0] n_r, d_r, rem_r;
  logic [46:0] q_r;
  logic [48:0] rem2;

  assign rem2 = {rem_r, 1'b0};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      init_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        init_r <= 1'b1;
      end else if (busy_r && init_r) begin
        init_r <= 1'b0;
        cnt_r  <= FRAC_BITS;
        if ({1'b0, n_r} >= {d_r, 1'b0}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division datapath
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num[47] ? 48'(-num) : 48'(num);
      d_r   <= den;
      neg_r <= num[47];
    end else if (busy_r && init_r) begin
      if ({1'b0, n_r} >= {d_r, 1'b0}) begin
        q_r <= '1;
      end else if (n_r >= d_r) begin
        q_r   <= 47'd1;
        rem_r <= n_r - d_r;
      end else begin
        q_r   <= '0;
        rem_r <= n_r;
      end
    end else if (busy_r) begin
      if (rem2 >= {1'b0, d_r}) begin
        rem_r <= 48'(rem2 - {1'b0, d_r});
        q_r   <= {q_r[45:0], 1'b1};
      end else begin
        rem_r <= rem2[47:0];
        q_r   <= {q_r[45:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

[bench/yaw_bias_kalman_filter_tb.sv]
// Testbench for the yaw / gyro-bias Kalman filter: random and directed input
// words, a fixed-point predictor of the filter and a checker on every result.
// Depends on ybkf_pkg, ybkf_if and yaw_bias_kalman_filter.
`timescale 1ns / 1ps

module yaw_bias_kalman_filter_tb;
  import ybkf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               action;
    logic signed [31:0] gyro_rate;
    logic signed [31:0] measured_yaw;
    logic [23:0]        time_step;
  } sample_t;

  typedef struct {
    logic [31:0] yaw;
    logic [31:0] bias;
  } estimate_t;

  localparam logic        ACT_STEP     = 1'b0;
  localparam logic        ACT_REINIT   = 1'b1;
  localparam logic [2:0]  UNUSED_INDEX = 3'd7;
  localparam int          CYCLE_LIMIT  = 3000000;
  localparam int          DRAIN_CYCLES = 400;
  localparam logic [46:0] NOISE_MAX    = 47'h7FFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;

  ybkf_in_if  in_ch();
  ybkf_out_if out_ch();
  ybkf_cfg_if cfg_ch();

  yaw_bias_kalman_filter DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter state and register copies
  wide_t est_yaw, est_bias, p00, p01, p10, p11;
  wide_t q_yaw, q_bias, r_meas, init_yaw, init_bias;

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  int errors = 0;
  int words_queued = 0;
  int words_checked = 0;
  int cycles = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  function automatic wide_t clamp(wide_t v, int w);
    wide_t hi;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // exact product, rounded half away from zero, magnitude capped at 2^62
  function automatic wide_t round_mul(wide_t a, wide_t b, int s);
    wide_t ma, mb, r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r = (ma * mb + (wide_t'(1) <<< (s - 1))) >>> s;
    if (r > wide_t'(MAG_CAP)) r = wide_t'(MAG_CAP);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Q2.46 gain, truncated toward zero, saturated
  function automatic wide_t kalman_gain(wide_t num, wide_t den);
    wide_t n, q;
    n = (num < 0) ? -num : num;
    if (n / den >= 2) q = (wide_t'(1) <<< 47) - 1;
    else q = (n <<< 46) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void load_initial();
    est_yaw = init_yaw;
    est_bias = init_bias;
    p00 = COV_YY_INIT;
    p01 = 0;
    p10 = 0;
    p11 = COV_BB_INIT;
  endfunction

  function automatic void reset_filter();
    q_yaw = NOISE_YAW_RST;
    q_bias = NOISE_BIAS_RST;
    r_meas = MEAS_NOISE_RST;
    init_yaw = 0;
    init_bias = 0;
    load_initial();
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_NOISE_YAW:  q_yaw = wide_t'(val[46:0]);
      REG_NOISE_BIAS: q_bias = wide_t'(val[46:0]);
      REG_MEAS_NOISE: r_meas = wide_t'(val[46:0]);
      REG_INIT_YAW:   init_yaw = wide_t'($signed(val[31:0]));
      REG_INIT_BIAS:  init_bias = wide_t'($signed(val[31:0]));
      default: ;
    endcase
  endfunction

  // predict and update on one accepted word; queue the estimate it yields
  function automatic void filter_word(sample_t s);
    wide_t rate, meas, dt, yawp, a00, a01, a10, a11, innov, sden, g0, g1, omg;
    estimate_t e;
    if (s.action == ACT_REINIT) begin
      load_initial();
    end else begin
      rate = s.gyro_rate;
      meas = s.measured_yaw;
      dt = wide_t'(s.time_step);
      yawp = clamp(est_yaw + round_mul(rate - est_bias, dt, 24), 32);
      a01 = p01 - round_mul(p11, dt, 24);
      a00 = p00 - round_mul(p10, dt, 24);
      a00 = clamp(a00 - round_mul(a01, dt, 24) + q_yaw, 48);
      a10 = clamp(p10 - round_mul(p11, dt, 24), 48);
      a11 = clamp(p11 + q_bias, 48);
      a01 = clamp(a01, 48);
      innov = meas - yawp;
      if (innov > PI_Q24) innov = innov - TWO_PI_Q24;
      if (innov < -wide_t'(PI_Q24)) innov = innov + TWO_PI_Q24;
      sden = a00 + r_meas;
      if (sden > 0) begin
        g0 = kalman_gain(a00, sden);
        g1 = kalman_gain(a10, sden);
      end else begin
        g0 = 0;
        g1 = 0;
      end
      est_yaw = clamp(yawp + round_mul(g0, innov, 46), 32);
      est_bias = clamp(est_bias + round_mul(g1, innov, 46), 32);
      omg = ONE_Q46 - g0;
      p00 = clamp(round_mul(omg, a00, 46), 48);
      p01 = clamp(round_mul(omg, a01, 46), 48);
      p10 = clamp(a10 - round_mul(g1, a00, 46), 48);
      p11 = clamp(a11 - round_mul(g1, a01, 46), 48);
    end
    e.yaw = est_yaw[31:0];
    e.bias = est_bias[31:0];
    expected_estimates.push_back(e);
  endfunction

  function automatic int idle_draw(bit on);
    if (!on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      filter_word('{in_ch.action, in_ch.gyro_rate, in_ch.measured_yaw, in_ch.time_step});
      in_gap = idle_draw(in_idle_on);
      if (in_gap == 0 && pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_ch.action <= s.action;
        in_ch.gyro_rate <= s.gyro_rate;
        in_ch.measured_yaw <= s.measured_yaw;
        in_ch.time_step <= s.time_step;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end else if (!in_ch.valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_ch.action <= s.action;
        in_ch.gyro_rate <= s.gyro_rate;
        in_ch.measured_yaw <= s.measured_yaw;
        in_ch.time_step <= s.time_step;
        in_ch.valid <= 1'b1;
      end
    end
  end

  // result monitor with random receiver stalls
  int out_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_estimates.size() == 0) begin
        $error("unexpected result word: yaw_out %0d bias_out %0d",
               out_ch.yaw_out, out_ch.bias_out);
        errors++;
      end else begin
        estimate_t e;
        e = expected_estimates.pop_front();
        if (out_ch.yaw_out !== e.yaw) begin
          $error("yaw_out expected %0d actual %0d", $signed(e.yaw), out_ch.yaw_out);
          errors++;
        end
        if (out_ch.bias_out !== e.bias) begin
          $error("bias_out expected %0d actual %0d", $signed(e.bias), out_ch.bias_out);
          errors++;
        end
        words_checked++;
      end
      out_stall = idle_draw(out_idle_on);
      if (out_stall > 0) out_ch.ready <= 1'b0;
    end else if (!out_ch.ready) begin
      if (out_stall > 0) out_stall--;
      else out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    write_register(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_word(logic act, logic [31:0] rate, logic [31:0] meas, logic [23:0] dt);
    pending_samples.push_back('{act, rate, meas, dt});
    words_queued++;
  endtask

  // sender holds off until every queued word has come back
  task automatic wait_drained();
    while (words_checked < words_queued) @(posedge clk);
  endtask

  function automatic logic [63:0] noise_word(logic [46:0] v);
    return {17'($urandom_range(0, 131071)), v};
  endfunction

  function automatic logic [46:0] realistic_noise();
    return 47'($urandom_range(1, 1 << 20)) << $urandom_range(0, 20);
  endfunction

  // random words: mostly plausible motion, some full-range noise
  task automatic queue_random_words(int count);
    logic [31:0] rate, meas;
    logic [23:0] dt;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_word(ACT_REINIT, $urandom, $urandom, 24'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          rate = $urandom;
          meas = $urandom;
          dt = 24'($urandom);
        end else begin
          rate = $urandom_range(0, 1 << 27) - (1 << 26);
          meas = $urandom_range(0, 1 << 28) - (1 << 27);
          dt = 24'($urandom_range(0, 1 << 18));
        end
        queue_word(ACT_STEP, rate, meas, dt);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_STEP;
    in_ch.gyro_rate = '0;
    in_ch.measured_yaw = '0;
    in_ch.time_step = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_NOISE_YAW;
    cfg_ch.data = '0;
    reset_filter();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and innovation wrap, default registers
    queue_word(ACT_REINIT, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    queue_word(ACT_STEP, 32'd0, 32'd0, 24'd0);
    queue_word(ACT_STEP, 32'h0100_0000, 32'd0, 24'd16777);
    queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    queue_word(ACT_STEP, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
    queue_word(ACT_REINIT, 32'd0, 32'd0, 24'd0);
    queue_word(ACT_STEP, 32'd0, 32'd60000000, 24'd0);
    queue_word(ACT_STEP, 32'd0, -32'sd60000000, 24'd0);
    queue_word(ACT_STEP, 32'd0, 32'd52707179, 24'd0);
    queue_word(ACT_STEP, 32'd0, 32'h7FFF_FFFF, 24'd1);
    queue_word(ACT_STEP, 32'd0, 32'h8000_0000, 24'd1);
    queue_word(ACT_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h80_0000);
    wait_drained();

    // directed: zero noise drives the innovation variance to zero
    cfg_write(REG_NOISE_YAW, 64'd0);
    cfg_write(REG_NOISE_BIAS, 64'd0);
    cfg_write(REG_MEAS_NOISE, 64'd0);
    cfg_write(REG_INIT_YAW, 64'h0000_0000_7FFF_FFFF);
    cfg_write(REG_INIT_BIAS, 64'hFFFF_FFFF_8000_0000);
    cfg_write(UNUSED_INDEX, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(ACT_REINIT, 32'd0, 32'd0, 24'd0);
    queue_word(ACT_STEP, 32'd1000, 32'd0, 24'd0);
    queue_word(ACT_STEP, 32'd1000, 32'd5000, 24'd0);
    queue_word(ACT_STEP, 32'd1000, 32'd5000, 24'd100);
    queue_word(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    wait_drained();

    // random phases, each with its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      in_idle_on = (phase != 2);
      out_idle_on = (phase != 3);
      case (phase)
        0: begin
          cfg_write(REG_NOISE_YAW, noise_word(NOISE_MAX));
          cfg_write(REG_NOISE_BIAS, noise_word(NOISE_MAX));
          cfg_write(REG_MEAS_NOISE, noise_word(NOISE_MAX));
          cfg_write(REG_INIT_YAW, {$urandom, 32'h8000_0000});
          cfg_write(REG_INIT_BIAS, {$urandom, 32'h7FFF_FFFF});
        end
        1: begin
          cfg_write(REG_NOISE_YAW, noise_word(47'd0));
          cfg_write(REG_NOISE_BIAS, noise_word(47'd0));
          cfg_write(REG_MEAS_NOISE, noise_word(47'd1));
          cfg_write(REG_INIT_YAW, {$urandom, $urandom});
          cfg_write(REG_INIT_BIAS, {$urandom, $urandom});
        end
        default: begin
          cfg_write(REG_NOISE_YAW, noise_word(realistic_noise()));
          cfg_write(REG_NOISE_BIAS, noise_word(realistic_noise()));
          cfg_write(REG_MEAS_NOISE, noise_word(realistic_noise()));
          cfg_write(REG_INIT_YAW, {$urandom, 32'($urandom_range(0, 1 << 27)) - (1 << 26)});
          cfg_write(REG_INIT_BIAS, {$urandom, 32'($urandom_range(0, 1 << 22)) - (1 << 21)});
        end
      endcase
      queue_word(ACT_REINIT, 32'd0, 32'd0, 24'd0);
      queue_random_words(254);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_estimates.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
